// ===== hw/rtl/clr_pkg.sv =====
package clr_pkg;

  // Widest cell index over the full parameter range (128 x 128 cells).
  localparam int MAX_AW = 14;

  // Bresenham error term: holds values between about -510 and +510.
  localparam int ERR_W = 12;

  // One plotted point travelling from the line walker to the frame store.
  typedef struct packed {
    logic              valid;
    logic              wr;
    logic              last;
    logic [MAX_AW-1:0] addr;
    logic [7:0]        glyph;
  } plot_t;

  // True when a signed point lies inside a cols x rows frame.
  function automatic logic in_frame(logic signed [7:0] x, logic signed [7:0] y,
                                    logic [7:0] cols, logic [7:0] rows);
    return !x[7] && !y[7] && ({1'b0, x[6:0]} < cols) && ({1'b0, y[6:0]} < rows);
  endfunction

  // Row-major cell index of an in-frame point.
  function automatic logic [MAX_AW-1:0] cell_index(logic [6:0] col, logic [6:0] row,
                                                   logic [7:0] cols);
    return MAX_AW'(row) * MAX_AW'(cols) + MAX_AW'(col);
  endfunction

endpackage

// ===== hw/rtl/clr_walker.sv =====
module clr_walker import clr_pkg::*; #(
  parameter int COLS = 64,
  parameter int ROWS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic signed [7:0] x_start,
  input  logic signed [7:0] y_start,
  input  logic signed [7:0] x_end,
  input  logic signed [7:0] y_end,
  input  logic [7:0]        glyph,
  output plot_t             plot
);

  logic                    swap;
  logic signed [7:0]       xa, ya, xb, yb;
  logic signed [8:0]       dyv;
  logic [7:0]              adx, ady;
  logic                    shallow;
  logic                    low_b;
  logic signed [7:0]       sx, sy, ox;
  logic signed [7:0]       m_init, n_init;
  logic [7:0]              dmaj, dmin;
  logic                    up_init;

  logic                    busy;
  logic                    steep;
  logic signed [7:0]       m, n;
  logic [7:0]              cnt;
  logic signed [ERR_W-1:0] err;
  logic signed [ERR_W-1:0] inc_pos, inc_neg;
  logic                    up;
  logic [7:0]              glyph_r;
  logic signed [7:0]       px, py;

  // Order the endpoints by x and pick the major axis.
  always_comb begin
    swap    = x_start > x_end;
    xa      = swap ? x_end   : x_start;
    ya      = swap ? y_end   : y_start;
    xb      = swap ? x_start : x_end;
    yb      = swap ? y_start : y_end;
    adx     = 8'({xb[7], xb} - {xa[7], xa});
    dyv     = {yb[7], yb} - {ya[7], ya};
    ady     = dyv[8] ? 8'(-dyv) : dyv[7:0];
    shallow = ady < adx;
    // Steep lines walk upward from the endpoint with the lower row.
    low_b   = ya > yb;
    sx      = low_b ? xb : xa;
    sy      = low_b ? yb : ya;
    ox      = low_b ? xa : xb;
    m_init  = shallow ? xa  : sy;
    n_init  = shallow ? ya  : sx;
    dmaj    = shallow ? adx : ady;
    dmin    = shallow ? ady : adx;
    up_init = shallow ? (yb > ya) : (ox > sx);
  end

  // Step the walk one point per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy    <= 1'b1;
      steep   <= !shallow;
      m       <= m_init;
      n       <= n_init;
      cnt     <= dmaj;
      up      <= up_init;
      glyph_r <= glyph;
      err     <= $signed({3'b0, dmin, 1'b0}) - $signed({4'b0, dmaj});
      inc_pos <= $signed({3'b0, dmin, 1'b0});
      inc_neg <= $signed({3'b0, dmin, 1'b0}) - $signed({3'b0, dmaj, 1'b0});
    end else if (busy) begin
      m   <= m + 8'sd1;
      cnt <= cnt - 8'd1;
      if (err > 0) begin
        n   <= up ? n + 8'sd1 : n - 8'sd1;
        err <= err + inc_neg;
      end else begin
        err <= err + inc_pos;
      end
      if (cnt == 8'd0) begin
        busy <= 1'b0;
      end
    end
  end

  assign px = steep ? n : m;
  assign py = steep ? m : n;

  // Register the current point toward the store; off-frame points are not written.
  always_ff @(posedge clk) begin
    if (rst) begin
      plot <= '0;
    end else begin
      plot.valid <= busy;
      plot.wr    <= busy && in_frame(px, py, 8'(COLS), 8'(ROWS));
      plot.last  <= busy && (cnt == 8'd0);
      plot.addr  <= cell_index(px[6:0], py[6:0], 8'(COLS));
      plot.glyph <= glyph_r;
    end
  end

  // A new line never starts on top of one still being walked.
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("line start while walker busy");

  // Points of one line come out in consecutive cycles.
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    plot.valid && !plot.last |=> plot.valid)
    else $error("gap inside a line walk");

endmodule

// ===== hw/rtl/clr_store.sv =====
module clr_store import clr_pkg::*; #(
  parameter int COLS = 64,
  parameter int ROWS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  plot_t             plot,
  input  logic              rd_en,
  input  logic [MAX_AW-1:0] rd_addr,
  output logic [7:0]        rd_data,
  output logic              clearing
);

  localparam int DEPTH = COLS * ROWS;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;

  // Clearing pass after reset, one cell per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Single write port: clearing pass or plotted point.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'd0;
    end else if (plot.wr) begin
      mem[plot.addr[AW-1:0]] <= plot.glyph;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr[AW-1:0]];
    end
  end

  // The walker never writes while the clearing pass owns the port.
  a_no_clash: assert property (@(posedge clk) disable iff (rst) !(clearing && plot.wr))
    else $error("plot write during clearing pass");

endmodule

// ===== hw/rtl/clipped_line_rasterizer.sv =====
// Channel | Direction | Handshake            | Beat contents
// in      | input     | in_valid / in_stall  | mode, x_start, y_start, x_end, y_end, glyph
// out     | output    | out_valid / out_stall| cell_value, cell_valid
//
// A draw goes from accept through the walker to the result: the store has one
// write port and the walker plots one point into it per cycle (up to 256 points).
// For a read, the store read is registered, then the result is loaded.
// After reset the store is cleared one cell per cycle, all COLS*ROWS cells (2048 by
// default), with in_stall high. One item is in flight at a time; a finished result
// waits in the output register while the next item is accepted.
module clipped_line_rasterizer import clr_pkg::*; #(
  parameter int COLS = 64,
  parameter int ROWS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              mode,
  input  logic signed [7:0] x_start,
  input  logic signed [7:0] y_start,
  input  logic signed [7:0] x_end,
  input  logic signed [7:0] y_end,
  input  logic [7:0]        glyph,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        cell_value,
  output logic              cell_valid
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_DRAW   = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t            state;
  logic              accept;
  logic              read_hit;
  logic              rd_en;
  logic [MAX_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              clearing;
  logic              start;
  plot_t             plot;
  logic [7:0]        res_value;
  logic              res_valid;
  logic              load_out;

  // Input side: one item at a time.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign read_hit = in_frame(x_start, y_start, 8'(COLS), 8'(ROWS));
  assign rd_en    = accept && mode && read_hit;
  assign rd_addr  = cell_index(x_start[6:0], y_start[6:0], 8'(COLS));
  assign start    = accept && !mode;
  assign load_out = (state == S_FINISH) && (!out_valid || !out_stall);

  clr_walker #(.COLS(COLS), .ROWS(ROWS)) u_walker (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .x_start (x_start),
    .y_start (y_start),
    .x_end   (x_end),
    .y_end   (y_end),
    .glyph   (glyph),
    .plot    (plot)
  );

  clr_store #(.COLS(COLS), .ROWS(ROWS)) u_store (
    .clk      (clk),
    .rst      (rst),
    .plot     (plot),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  // Control sequence for one item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      case (state)
        S_CLEAR: begin
          if (!clearing) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_value <= 8'd0;
            res_valid <= 1'b0;
            if (!mode) begin
              state <= S_DRAW;
            end else if (read_hit) begin
              state <= S_RDWAIT;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_DRAW: begin
          if (plot.valid && plot.last) begin
            state <= S_FINISH;
          end
        end
        S_RDWAIT: begin
          res_value <= rd_data;
          res_valid <= 1'b1;
          state     <= S_FINISH;
        end
        S_FINISH: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      cell_value <= res_value;
      cell_valid <= res_valid;
    end
  end

  // Read data is only captured in the cycle after a store read was issued.
  a_rd_latency: assert property (@(posedge clk) disable iff (rst)
    state == S_RDWAIT |-> $past(rd_en))
    else $error("read result without a store read");

  // The last point of a line only arrives while a draw is in progress.
  a_last_in_draw: assert property (@(posedge clk) disable iff (rst)
    plot.valid && plot.last |-> state == S_DRAW)
    else $error("line end outside a draw");

endmodule

// ===== tb/tb_clipped_line_rasterizer.sv =====
module tb_clipped_line_rasterizer;

  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 32;
  localparam bit MODE_DRAW = 1'b0;
  localparam bit MODE_READ = 1'b1;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_ITEMS = 1075;
  localparam int QUIET_TAIL = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // One line or cell request as it goes over the input channel.
  typedef struct {
    bit               mode;
    logic signed [7:0] col_a;
    logic signed [7:0] row_a;
    logic signed [7:0] col_b;
    logic signed [7:0] row_b;
    logic [7:0]       glyph;
  } line_cmd_t;

  // One beat of the result channel.
  typedef struct {
    logic [7:0] value;
    logic       valid;
  } cell_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              mode = MODE_DRAW;
  logic signed [7:0] x_start = '0;
  logic signed [7:0] y_start = '0;
  logic signed [7:0] x_end = '0;
  logic signed [7:0] y_end = '0;
  logic [7:0]        glyph = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        cell_value;
  logic              cell_valid;

  line_cmd_t    pending_cmds[$];
  line_cmd_t    cur_cmd;
  cell_result_t expected_cells[$];
  logic [7:0]   frame_image [GRID_COLS*GRID_ROWS] = '{default: '0};

  bit in_fire = 1'b0;
  bit hold_off = 1'b0;
  int total_cmds = 0;
  int accepted_cmds = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;

  clipped_line_rasterizer #(
    .COLS(GRID_COLS),
    .ROWS(GRID_ROWS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .glyph     (glyph),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_value(cell_value),
    .cell_valid(cell_valid)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic bit on_grid(int col, int row);
    return col >= 0 && row >= 0 && col < GRID_COLS && row < GRID_ROWS;
  endfunction

  // Points that fall off the frame are dropped, the walk itself goes on.
  function automatic void put_cell(int col, int row, logic [7:0] g);
    if (on_grid(col, row)) frame_image[row*GRID_COLS + col] = g;
  endfunction

  // Integer Bresenham over the frame image, endpoints ordered by column first.
  function automatic void rasterize_line(int xa, int ya, int xb, int yb, logic [7:0] g);
    int t, run, rise, dir, err, x, y, sx, sy, ey;
    if (xa > xb) begin
      t = xa; xa = xb; xb = t;
      t = ya; ya = yb; yb = t;
    end
    if (ya == yb) begin
      for (x = xa; x <= xb; x++) put_cell(x, ya, g);
    end else if (xa == xb) begin
      for (y = (ya < yb ? ya : yb); y <= (ya < yb ? yb : ya); y++) put_cell(xa, y, g);
    end else begin
      run  = xb - xa;
      rise = (yb > ya) ? yb - ya : ya - yb;
      if (rise < run) begin
        // Shallow: one point per column.
        dir = (yb > ya) ? 1 : -1;
        err = 2*rise - run;
        y = ya;
        for (x = xa; x <= xb; x++) begin
          put_cell(x, y, g);
          if (err > 0) begin
            y += dir;
            err -= 2*run;
          end
          err += 2*rise;
        end
      end else begin
        // Steep: one point per row, starting from the lower row.
        if (ya > yb) begin
          sx = xb; sy = yb; ey = ya; dir = -1;
        end else begin
          sx = xa; sy = ya; ey = yb; dir = 1;
        end
        err = 2*run - rise;
        x = sx;
        for (y = sy; y <= ey; y++) begin
          put_cell(x, y, g);
          if (err > 0) begin
            x += dir;
            err -= 2*rise;
          end
          err += 2*run;
        end
      end
    end
  endfunction

  // Applies one accepted request to the frame image and gives its result beat.
  function automatic cell_result_t apply_cmd(line_cmd_t c);
    cell_result_t r = '{value: '0, valid: 1'b0};
    if (c.mode == MODE_READ) begin
      if (on_grid(c.col_a, c.row_a)) begin
        r.value = frame_image[int'(c.row_a)*GRID_COLS + int'(c.col_a)];
        r.valid = 1'b1;
      end
    end else begin
      rasterize_line(c.col_a, c.row_a, c.col_b, c.row_b, c.glyph);
    end
    return r;
  endfunction

  function automatic void add_cmd(bit m, int ca, int ra, int cb, int rb, int g);
    line_cmd_t c;
    c.mode  = m;
    c.col_a = 8'(ca);
    c.row_a = 8'(ra);
    c.col_b = 8'(cb);
    c.row_b = 8'(rb);
    c.glyph = 8'(g);
    pending_cmds.push_back(c);
  endfunction

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic void report_fault(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // Stimulus, reset, and the end of the run.
  initial begin : run_test
    int g, kind, ca, ra;

    // Reads of the cleared frame, inside and outside.
    add_cmd(MODE_READ, 0, 0, 0, 0, 0);
    add_cmd(MODE_READ, 63, 31, 0, 0, 0);
    add_cmd(MODE_READ, 64, 0, 0, 0, 0);
    add_cmd(MODE_READ, 0, 32, 0, 0, 0);
    add_cmd(MODE_READ, -1, -1, 127, -128, 255);
    add_cmd(MODE_READ, 127, -128, -128, 127, 170);
    // Horizontal and vertical lines over the whole coordinate range.
    add_cmd(MODE_DRAW, -128, 5, 127, 5, 8'hff);
    add_cmd(MODE_DRAW, 10, 127, 10, -128, 8'h80);
    // Single point, shallow in both slopes, steep both ways, and a diagonal.
    add_cmd(MODE_DRAW, 3, 3, 3, 3, 8'h41);
    add_cmd(MODE_DRAW, 0, 0, 63, 20, 8'h01);
    add_cmd(MODE_DRAW, 63, 0, 0, 31, 8'h02);
    add_cmd(MODE_DRAW, 5, 0, 12, 31, 8'h03);
    add_cmd(MODE_DRAW, 0, 0, 31, 31, 8'h06);
    add_cmd(MODE_DRAW, 45, 0, 40, 31, 8'h05);
    // Full range diagonals, a line fully off the frame, a zero glyph, one crossing the edge.
    add_cmd(MODE_DRAW, -128, -128, 127, 127, 8'h7e);
    add_cmd(MODE_DRAW, 127, -128, -128, 127, 8'h7f);
    add_cmd(MODE_DRAW, -50, -50, -10, -20, 8'haa);
    add_cmd(MODE_DRAW, 0, 10, 20, 10, 8'h00);
    add_cmd(MODE_DRAW, 60, -20, 70, 50, 8'h55);
    // Read back, with junk in the unused fields.
    add_cmd(MODE_READ, 3, 3, -7, 99, 8'h3c);
    add_cmd(MODE_READ, 10, 5, 0, 0, 0);
    add_cmd(MODE_READ, 0, 0, 0, 0, 0);
    add_cmd(MODE_READ, 63, 31, 0, 0, 0);
    add_cmd(MODE_READ, 40, 31, 0, 0, 0);
    add_cmd(MODE_READ, 0, 10, 0, 0, 0);

    // Random mix: mostly lines near the frame and reads inside it.
    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(99) < 40) begin
        g = $urandom_range(255);
        kind = $urandom_range(99);
        ca = pick(-8, 71);
        ra = pick(-8, 39);
        if (kind < 10)
          add_cmd(MODE_DRAW, pick(-128, 127), pick(-128, 127), pick(-128, 127),
                  pick(-128, 127), g);
        else if (kind < 18)
          add_cmd(MODE_DRAW, ca, ra, pick(-8, 71), ra, g);
        else if (kind < 25)
          add_cmd(MODE_DRAW, ca, ra, ca, pick(-8, 39), g);
        else if (kind < 30)
          add_cmd(MODE_DRAW, ca, ra, ca, ra, g);
        else
          add_cmd(MODE_DRAW, ca, ra, pick(-8, 71), pick(-8, 39), g);
      end else if ($urandom_range(99) < 85) begin
        add_cmd(MODE_READ, pick(0, GRID_COLS-1), pick(0, GRID_ROWS-1), pick(-128, 127),
                pick(-128, 127), $urandom_range(255));
      end else begin
        add_cmd(MODE_READ, pick(-128, 127), pick(-128, 127), pick(-128, 127),
                pick(-128, 127), $urandom_range(255));
      end
    end
    total_cmds = pending_cmds.size();

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    wait (accepted_cmds == total_cmds);
    wait (expected_cells.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Long receiver hold-off so the block fills up and stalls its input.
  initial begin : result_hold_off
    wait (accepted_cmds >= 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Driver: presents requests at the falling edge, with random idle bursts.
  always @(negedge clk) begin : feed_cmds
    bit offer;
    offer = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_cmds.size() > 0) begin
        if (accepted_cmds < total_cmds - QUIET_TAIL && $urandom_range(4) == 0) begin
          send_gap = $urandom_range(4);
        end else begin
          cur_cmd = pending_cmds.pop_front();
          offer = 1'b1;
          mode    <= cur_cmd.mode;
          x_start <= cur_cmd.col_a;
          y_start <= cur_cmd.row_a;
          x_end   <= cur_cmd.col_b;
          y_end   <= cur_cmd.row_b;
          glyph   <= cur_cmd.glyph;
        end
      end
      in_valid <= offer;
    end
  end

  // Receiver: random stall bursts, none in the tail, plus the long hold-off.
  always @(negedge clk) begin : drain_results
    bit hold;
    hold = 1'b0;
    if (accepted_cmds >= total_cmds - QUIET_TAIL) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      hold = 1'b1;
      stall_left--;
    end else if (!rst && $urandom_range(3) == 0) begin
      hold = 1'b1;
      stall_left = $urandom_range(4);
    end
    out_stall <= hold || hold_off;
  end

  // Monitor: predicts on every accepted request, checks every accepted result beat.
  always @(posedge clk) begin : watch_channels
    cell_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      expected_cells.push_back(apply_cmd(cur_cmd));
      accepted_cmds++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        report_fault($sformatf("result beat with nothing pending: cell_value %0d cell_valid %0b",
                               cell_value, cell_valid));
      end else begin
        want = expected_cells.pop_front();
        if (cell_value !== want.value)
          report_fault($sformatf("cell_value expected %0d got %0d", want.value, cell_value));
        if (cell_valid !== want.valid)
          report_fault($sformatf("cell_valid expected %0b got %0b", want.valid, cell_valid));
      end
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/clr_pkg.sv
hw/rtl/clr_walker.sv
hw/rtl/clr_store.sv
hw/rtl/clipped_line_rasterizer.sv
tb/tb_clipped_line_rasterizer.sv
